// File: src/mstk_pkg.sv
// ----------------------------------------------------------------------------
// mstk_pkg
// Shared types and codes for the stack with minimum query: command and
// response beats, stored entry layout, action and status codes.
// ----------------------------------------------------------------------------
package mstk_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int VALUE_W       = 32;
  localparam int COUNT_OUT_W   = 7;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_MIN  = 2'd2;
  localparam logic [1:0] ACT_PEEK = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic signed [VALUE_W-1:0] MIN_OF_EMPTY = -32'sd1;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [VALUE_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [1:0]                status;
    logic [COUNT_OUT_W-1:0]    entry_count;
  } rsp_t;

  // One stack level: its value and the minimum of it and all levels below.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] level_min;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// File: src/mstk_ram.sv
// ----------------------------------------------------------------------------
// mstk_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mstk_ram #(
  parameter int WIDTH = mstk_pkg::ENTRY_W,
  parameter int DEPTH = mstk_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/stack_with_min_query_top.sv
// ----------------------------------------------------------------------------
// stack_with_min_query_top
// Bounded LIFO stack of signed values that also reports the stack minimum.
// ----------------------------------------------------------------------------
// Usage:
// A command beat on cmd carries an action (push, pop, min, peek) and a push
// value. Each command yields exactly one response beat on rsp with the
// result value, a status (ok, empty, full) and the entry count afterwards.
// Each level is stored in one RAM word together with the running minimum of
// the levels at and below it, so every action needs one read and at most one
// write of that RAM.
// A command is taken in the idle state, where the stack RAM read of the top
// level is issued; the response is registered in the execute state once the
// output register is free. A new command is taken only after that response
// has been registered, since the registered read of the stack RAM must
// return the top level before the action can complete.
// Reset clears the entry count, so the stack starts empty; the RAM is not
// cleared, since data read from levels at or above the count is never used.
// When the receiver stalls, the response is held. A command already taken
// waits with its read data until the output register frees up, and cmd_stall
// stays high during that time.
// ----------------------------------------------------------------------------
module stack_with_min_query_top #(
  parameter int DEPTH = mstk_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  mstk_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mstk_pkg::rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int OW = mstk_pkg::COUNT_OUT_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  mstk_pkg::state_t state, state_next;

  logic [CW-1:0]                       fill, fill_next;
  logic [1:0]                          act;
  logic signed [mstk_pkg::VALUE_W-1:0] pval;
  mstk_pkg::rsp_t                      rsp_next;

  logic                         accept, finish, out_free, empty, full;
  logic [CW-1:0]                top_idx;
  logic [CW+OW-1:0]             count_ext;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [mstk_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  mstk_pkg::entry_t             rd_entry, wr_entry;

  mstk_ram #(
    .WIDTH(mstk_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mstk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd_stall = (state != mstk_pkg::ST_IDLE);
    accept    = cmd_valid && !cmd_stall;
    out_free  = !rsp_valid || !rsp_stall;
    finish    = (state == mstk_pkg::ST_EXEC) && out_free;
    empty     = (fill == '0);
    full      = (fill == FULL_COUNT);
    top_idx   = fill - 1'b1;
    ram_raddr = top_idx[AW-1:0];
    ram_waddr = fill[AW-1:0];
    rd_entry  = mstk_pkg::entry_t'(ram_rdata);

    wr_entry.value     = pval;
    wr_entry.level_min = (!empty && (rd_entry.level_min < pval)) ? rd_entry.level_min : pval;
    ram_wdata          = wr_entry;
    ram_we             = 1'b0;

    fill_next             = fill;
    rsp_next.result_value = '0;
    rsp_next.status       = mstk_pkg::STAT_OK;

    unique case (act)
      mstk_pkg::ACT_PUSH: begin
        if (full) begin
          rsp_next.status = mstk_pkg::STAT_FULL;
        end else begin
          ram_we    = finish;
          fill_next = fill + 1'b1;
        end
      end
      mstk_pkg::ACT_POP: begin
        if (empty) begin
          rsp_next.status = mstk_pkg::STAT_EMPTY;
        end else begin
          rsp_next.result_value = rd_entry.value;
          fill_next             = top_idx;
        end
      end
      mstk_pkg::ACT_MIN: begin
        if (empty) begin
          rsp_next.status       = mstk_pkg::STAT_EMPTY;
          rsp_next.result_value = mstk_pkg::MIN_OF_EMPTY;
        end else begin
          rsp_next.result_value = rd_entry.level_min;
        end
      end
      mstk_pkg::ACT_PEEK: begin
        if (empty) begin
          rsp_next.status = mstk_pkg::STAT_EMPTY;
        end else begin
          rsp_next.result_value = rd_entry.value;
        end
      end
    endcase

    // The count field is the entry count masked to the output width.
    count_ext            = {{OW{1'b0}}, fill_next};
    rsp_next.entry_count = count_ext[OW-1:0];

    state_next = state;
    unique case (state)
      mstk_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = mstk_pkg::ST_EXEC;
        end
      end
      mstk_pkg::ST_EXEC: begin
        if (finish) begin
          state_next = mstk_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (finish) begin
        fill      <= fill_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= cmd.action;
      pval <= cmd.push_value;
    end
    if (finish) begin
      rsp <= rsp_next;
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_COUNT)
    else $error("entry count exceeds stack depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    finish && (act == mstk_pkg::ACT_PUSH) && !full |=> fill == $past(fill) + 1'b1)
    else $error("accepted push did not add one level");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == mstk_pkg::STAT_EMPTY) |-> fill == '0)
    else $error("empty status reported while the stack holds entries");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    finish |-> !(rsp_valid && rsp_stall))
    else $error("stalled response overwritten");

  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == mstk_pkg::ST_EXEC) && !accept)
    else $error("stack RAM written outside the execute step");
`endif

endmodule

// File: tb/min_stack_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_stack_checker
// Watches the command and response channels of the min stack, keeps its own
// copy of the stack with a running minimum per level, and compares every
// response beat field by field with the oldest predicted response.
// ----------------------------------------------------------------------------
module min_stack_checker #(
  parameter int DEPTH = mstk_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  logic           cmd_stall,
  input  mstk_pkg::cmd_t cmd,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  mstk_pkg::rsp_t rsp,
  output int             mismatch_count,
  output int             outstanding
);

  logic signed [mstk_pkg::VALUE_W-1:0] shadow_values [DEPTH];
  logic signed [mstk_pkg::VALUE_W-1:0] shadow_mins   [DEPTH];
  int                                  shadow_fill;
  mstk_pkg::rsp_t                      awaited_rsps[$];

  // Applies one command to the shadow stack and returns the response it owes.
  function automatic mstk_pkg::rsp_t apply_cmd(input mstk_pkg::cmd_t c);
    mstk_pkg::rsp_t                      r;
    logic signed [mstk_pkg::VALUE_W-1:0] run_min;
    r.result_value = '0;
    r.status       = mstk_pkg::STAT_OK;
    case (c.action)
      mstk_pkg::ACT_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          r.status = mstk_pkg::STAT_FULL;
        end else begin
          run_min = c.push_value;
          if (shadow_fill > 0 && shadow_mins[shadow_fill-1] < c.push_value)
            run_min = shadow_mins[shadow_fill-1];
          shadow_values[shadow_fill] = c.push_value;
          shadow_mins[shadow_fill]   = run_min;
          shadow_fill++;
        end
      end
      mstk_pkg::ACT_POP: begin
        if (shadow_fill == 0) begin
          r.status = mstk_pkg::STAT_EMPTY;
        end else begin
          shadow_fill--;
          r.result_value = shadow_values[shadow_fill];
        end
      end
      mstk_pkg::ACT_MIN: begin
        if (shadow_fill == 0) begin
          r.status       = mstk_pkg::STAT_EMPTY;
          r.result_value = mstk_pkg::MIN_OF_EMPTY;
        end else begin
          r.result_value = shadow_mins[shadow_fill-1];
        end
      end
      default: begin
        if (shadow_fill == 0)
          r.status = mstk_pkg::STAT_EMPTY;
        else
          r.result_value = shadow_values[shadow_fill-1];
      end
    endcase
    r.entry_count = shadow_fill[mstk_pkg::COUNT_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    mstk_pkg::rsp_t want;
    if (rst) begin
      shadow_fill = 0;
      awaited_rsps.delete();
    end else begin
      // A response beat never belongs to a command taken at the same edge,
      // so responses are matched before the new command is predicted.
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsps.size() == 0) begin
          $error("response beat with no command waiting: value %0d status %0d count %0d",
                 rsp.result_value, rsp.status, rsp.entry_count);
          mismatch_count++;
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp.result_value !== want.result_value) begin
            $error("result_value expected %0d actual %0d",
                   want.result_value, rsp.result_value);
            mismatch_count++;
          end
          if (rsp.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, rsp.status);
            mismatch_count++;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $error("entry_count expected %0d actual %0d",
                   want.entry_count, rsp.entry_count);
            mismatch_count++;
          end
        end
      end
      if (cmd_valid && !cmd_stall)
        awaited_rsps.push_back(apply_cmd(cmd));
    end
    outstanding = awaited_rsps.size();
  end

endmodule

// File: tb/tb_stack_with_min_query_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stack_with_min_query_top
// Drives the min stack with directed corner cases and then with random
// command runs that fill, drain and overflow the stack, with random idle
// bursts on both channels. A separate checker predicts every response.
// ----------------------------------------------------------------------------
module tb_stack_with_min_query_top;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CALM_ITEMS   = 200;
  localparam int IDLE_LIMIT   = 5000;

  logic           clk;
  logic           rst;
  logic           cmd_valid;
  logic           cmd_stall;
  mstk_pkg::cmd_t cmd;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  mstk_pkg::rsp_t rsp;

  int             mismatch_count;
  int             outstanding;
  int             idle_pct;
  bit             calm;
  int             stall_left;

  stack_with_min_query_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  min_stack_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .cmd            (cmd),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver back-pressure in bursts of random length.
  always @(posedge clk) begin
    if (rst || calm) begin
      stall_left <= 0;
      rsp_stall  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_stall  <= 1'b1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 3);
      rsp_stall  <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Ends the run when no beat moves on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Half the values lie near the signed extremes or in a narrow band around zero,
  // so that ties and sign boundaries in the running minimum come up often.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
      1:       v = 32'h8000_0000 + 32'($urandom_range(0, 3));
      2:       v = 32'($urandom_range(0, 15)) - 32'd8;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic issue_cmd(input logic [1:0] act, input logic signed [31:0] val);
    cmd_valid       <= 1'b1;
    cmd.action      <= act;
    cmd.push_value  <= val;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      cmd_valid <= 1'b0;
      cmd       <= mstk_pkg::cmd_t'({$urandom(), $urandom()});
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  initial begin
    int         sent;
    int         seg_len;
    int         push_pct;
    int         pick;
    bit         first_seg;
    logic [1:0] act;

    cmd_valid <= 1'b0;
    cmd       <= '0;
    calm      = 1'b0;
    idle_pct  = 30;
    rst       <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty stack: pop, peek and min all report empty.
    issue_cmd(mstk_pkg::ACT_POP,  $urandom());
    issue_cmd(mstk_pkg::ACT_PEEK, $urandom());
    issue_cmd(mstk_pkg::ACT_MIN,  $urandom());
    // Signed extremes and the sign boundary in the running minimum.
    issue_cmd(mstk_pkg::ACT_PUSH, 32'h7FFF_FFFF);
    issue_cmd(mstk_pkg::ACT_MIN,  $urandom());
    issue_cmd(mstk_pkg::ACT_PEEK, $urandom());
    issue_cmd(mstk_pkg::ACT_PUSH, 32'h8000_0000);
    issue_cmd(mstk_pkg::ACT_MIN,  $urandom());
    issue_cmd(mstk_pkg::ACT_PUSH, 32'h0000_0000);
    issue_cmd(mstk_pkg::ACT_MIN,  $urandom());
    issue_cmd(mstk_pkg::ACT_PEEK, $urandom());
    issue_cmd(mstk_pkg::ACT_PUSH, 32'hFFFF_FFFF);
    issue_cmd(mstk_pkg::ACT_PUSH, 32'h0000_0001);
    issue_cmd(mstk_pkg::ACT_MIN,  $urandom());
    issue_cmd(mstk_pkg::ACT_POP,  $urandom());
    issue_cmd(mstk_pkg::ACT_POP,  $urandom());
    issue_cmd(mstk_pkg::ACT_MIN,  $urandom());
    issue_cmd(mstk_pkg::ACT_POP,  $urandom());
    issue_cmd(mstk_pkg::ACT_POP,  $urandom());
    issue_cmd(mstk_pkg::ACT_MIN,  $urandom());
    issue_cmd(mstk_pkg::ACT_POP,  $urandom());
    issue_cmd(mstk_pkg::ACT_POP,  $urandom());
    issue_cmd(mstk_pkg::ACT_MIN,  $urandom());

    // Random runs with a push bias per run; the first run is long and strongly
    // biased to push so that dropped pushes come up early.
    sent      = 0;
    first_seg = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (first_seg) begin
        seg_len  = 90;
        push_pct = 85;
      end else begin
        seg_len = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      first_seg = 1'b0;
      idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
      for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
        calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
        if ($urandom_range(0, 99) < push_pct) begin
          act = mstk_pkg::ACT_PUSH;
        end else begin
          pick = $urandom_range(0, 3);
          if (pick < 2)
            act = mstk_pkg::ACT_POP;
          else if (pick == 2)
            act = mstk_pkg::ACT_MIN;
          else
            act = mstk_pkg::ACT_PEEK;
        end
        issue_cmd(act, (act == mstk_pkg::ACT_PUSH) ? pick_value() : $urandom());
        sent++;
      end
    end
    cmd_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
